[rtl/rbe_pkg.sv]
// Shared constants, command codes and controller/datapath types for the
// run-length byte encoder. No dependencies; used by every file but rbe_ram.
`default_nettype none

package rbe_pkg;

    // Field widths of the request channels.
    localparam int DATA_W  = 8;
    localparam int CODE_W  = 64;
    localparam int COUNT_W = 4;
    localparam int SLOT_W  = 3;   // byte lane index within one result word

    // Default chunk limits and result packing.
    localparam int C_MAX_RUN_CHUNK      = 128;
    localparam int C_MAX_LITERAL_CHUNK  = 128;
    localparam int C_BYTES_PER_RESULT   = 8;

    // A literal header carries the literal length plus this bias.
    localparam int LIT_HDR_BIAS = 127;

    // State update commands from the controller to the datapath.
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
    localparam logic [OP_W-1:0] OP_START     = 4'd1;
    localparam logic [OP_W-1:0] OP_OPEN_RUN  = 4'd2;
    localparam logic [OP_W-1:0] OP_SPLIT_RUN = 4'd3;
    localparam logic [OP_W-1:0] OP_GROW      = 4'd4;
    localparam logic [OP_W-1:0] OP_END_RUN   = 4'd5;
    localparam logic [OP_W-1:0] OP_ADD_LIT   = 4'd6;
    localparam logic [OP_W-1:0] OP_FIN_RUN   = 4'd7;
    localparam logic [OP_W-1:0] OP_FIN_LIT   = 4'd8;
    localparam logic [OP_W-1:0] OP_CLEAR     = 4'd9;

    // Source of the code byte offered to the packer.
    localparam logic [1:0] SEL_HDR      = 2'd0;
    localparam logic [1:0] SEL_RAM      = 2'd1;
    localparam logic [1:0] SEL_RUN_CNT  = 2'd2;
    localparam logic [1:0] SEL_RUN_BYTE = 2'd3;

    typedef struct packed {
        logic            take;        // input request accepted this cycle
        logic [OP_W-1:0] op;
        logic            byte_valid;  // a code byte is offered to the packer
        logic [1:0]      byte_sel;
        logic            byte_last;   // final code byte of the current request
    } t_cmd;

    typedef struct packed {
        logic have_prev;
        logic same_byte;
        logic run_open;
        logic run_full;
        logic fin_in;
        logic fin;
        logic lit_empty;
        logic lit_fill;
        logic lit_at_end;
        logic stall;
    } t_status;

endpackage

`default_nettype wire

[rtl/rbe_in_if.sv]
// Input request channel of the run-length byte encoder: one raw byte per request.
// Depends on rbe_pkg for the field width.
`default_nettype none

interface rbe_in_if;
    logic                       valid;
    logic                       ready;
    logic [rbe_pkg::DATA_W-1:0] data_byte;
    logic                       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

`default_nettype wire

[rtl/rbe_out_if.sv]
// Output request channel of the run-length byte encoder: up to eight code bytes.
// Depends on rbe_pkg for the field widths.
`default_nettype none

interface rbe_out_if;
    logic                        valid;
    logic                        ready;
    logic [rbe_pkg::CODE_W-1:0]  code_bytes;
    logic [rbe_pkg::COUNT_W-1:0] code_count;
    logic                        last_of_item;

    modport source (output valid, output code_bytes, output code_count,
                    output last_of_item, input ready);
    modport sink   (input valid, input code_bytes, input code_count,
                    input last_of_item, output ready);
endinterface

`default_nettype wire

[rtl/rbe_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module rbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                             i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                             o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

[rtl/rbe_ctrl.sv]
// Sequencing controller of the run-length byte encoder: decides each request's
// state update and steps through run and literal packets. Depends on rbe_pkg.
`default_nettype none

module rbe_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire rbe_pkg::t_status i_status,
    output logic                  o_ready,
    output rbe_pkg::t_cmd         o_cmd
);
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_FIN      = 3'd1;
    localparam logic [2:0] S_RUN_A    = 3'd2;
    localparam logic [2:0] S_RUN_B    = 3'd3;
    localparam logic [2:0] S_LIT_HDR  = 3'd4;
    localparam logic [2:0] S_LIT_DATA = 3'd5;
    localparam logic [2:0] S_CLEAR    = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_phase, n_phase;   // set while the final-byte flush is under way
    logic       accept;
    logic       item_end;
    logic [2:0] after_pkt;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_in_valid && o_ready;
    // The closing byte of a packet ends the request unless the flush still follows.
    assign item_end = r_phase || !i_status.fin;
    assign after_pkt = r_phase ? S_CLEAR : (i_status.fin ? S_FIN : S_IDLE);

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.take = 1'b1;
                    n_phase    = 1'b0;
                    if (!i_status.have_prev) begin
                        o_cmd.op = rbe_pkg::OP_START;
                        n_state  = i_status.fin_in ? S_FIN : S_IDLE;
                    end else if (i_status.same_byte && !i_status.run_open) begin
                        o_cmd.op = rbe_pkg::OP_OPEN_RUN;
                        if (!i_status.lit_empty) begin
                            n_state = S_LIT_HDR;
                        end else begin
                            n_state = i_status.fin_in ? S_FIN : S_IDLE;
                        end
                    end else if (i_status.same_byte && i_status.run_full) begin
                        o_cmd.op = rbe_pkg::OP_SPLIT_RUN;
                        n_state  = S_RUN_A;
                    end else if (i_status.same_byte) begin
                        o_cmd.op = rbe_pkg::OP_GROW;
                        n_state  = i_status.fin_in ? S_FIN : S_IDLE;
                    end else if (i_status.run_open) begin
                        o_cmd.op = rbe_pkg::OP_END_RUN;
                        n_state  = S_RUN_A;
                    end else begin
                        o_cmd.op = rbe_pkg::OP_ADD_LIT;
                        if (i_status.lit_fill) begin
                            n_state = S_LIT_HDR;
                        end else begin
                            n_state = i_status.fin_in ? S_FIN : S_IDLE;
                        end
                    end
                end
            end
            S_FIN: begin
                n_phase = 1'b1;
                if (i_status.run_open) begin
                    o_cmd.op = rbe_pkg::OP_FIN_RUN;
                    n_state  = S_RUN_A;
                end else begin
                    o_cmd.op = rbe_pkg::OP_FIN_LIT;
                    n_state  = S_LIT_HDR;
                end
            end
            S_RUN_A: begin
                o_cmd.byte_valid = 1'b1;
                o_cmd.byte_sel   = rbe_pkg::SEL_RUN_CNT;
                if (!i_status.stall) begin
                    n_state = S_RUN_B;
                end
            end
            S_RUN_B: begin
                o_cmd.byte_valid = 1'b1;
                o_cmd.byte_sel   = rbe_pkg::SEL_RUN_BYTE;
                o_cmd.byte_last  = item_end;
                if (!i_status.stall) begin
                    n_state = after_pkt;
                end
            end
            S_LIT_HDR: begin
                o_cmd.byte_valid = 1'b1;
                o_cmd.byte_sel   = rbe_pkg::SEL_HDR;
                if (!i_status.stall) begin
                    n_state = S_LIT_DATA;
                end
            end
            S_LIT_DATA: begin
                o_cmd.byte_valid = 1'b1;
                o_cmd.byte_sel   = rbe_pkg::SEL_RAM;
                o_cmd.byte_last  = i_status.lit_at_end && item_end;
                if (!i_status.stall && i_status.lit_at_end) begin
                    n_state = after_pkt;
                end
            end
            S_CLEAR: begin
                o_cmd.op = rbe_pkg::OP_CLEAR;
                n_phase  = 1'b0;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
                n_phase = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end
endmodule

`default_nettype wire

[rtl/rbe_datapath.sv]
// Datapath of the run-length byte encoder: run and literal state, literal store,
// code byte packer and output register. Depends on rbe_pkg and rbe_ram.
`default_nettype none

module rbe_datapath #(
    parameter int MAX_RUN_CHUNK     = rbe_pkg::C_MAX_RUN_CHUNK,
    parameter int MAX_LITERAL_CHUNK = rbe_pkg::C_MAX_LITERAL_CHUNK,
    parameter int BYTES_PER_RESULT  = rbe_pkg::C_BYTES_PER_RESULT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [rbe_pkg::DATA_W-1:0]  i_data_byte,
    input  wire logic                        i_final_byte,
    input  wire rbe_pkg::t_cmd               i_cmd,
    output rbe_pkg::t_status                 o_status,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [rbe_pkg::CODE_W-1:0]       o_code_bytes,
    output logic [rbe_pkg::COUNT_W-1:0]      o_code_count,
    output logic                             o_last_of_item
);
    localparam int DW  = rbe_pkg::DATA_W;
    localparam int CW  = rbe_pkg::CODE_W;
    localparam int NW  = rbe_pkg::COUNT_W;
    localparam int SW  = rbe_pkg::SLOT_W;
    localparam int LCW = $clog2(MAX_LITERAL_CHUNK + 1);
    localparam int AW  = (MAX_LITERAL_CHUNK > 1) ? $clog2(MAX_LITERAL_CHUNK) : 1;

    localparam logic [DW-1:0]  RUN_MAX   = DW'(MAX_RUN_CHUNK);
    localparam logic [LCW-1:0] LIT_MAX   = LCW'(MAX_LITERAL_CHUNK);
    localparam logic [SW-1:0]  LAST_SLOT = SW'(BYTES_PER_RESULT - 1);
    localparam logic [DW-1:0]  HDR_BIAS  = DW'(rbe_pkg::LIT_HDR_BIAS);

    logic           r_fin,      n_fin;
    logic [DW-1:0]  r_prev,     n_prev;
    logic           r_have,     n_have;
    logic [DW-1:0]  r_run_cnt,  n_run_cnt;
    logic           r_run_open, n_run_open;
    logic [LCW-1:0] r_lit_cnt,  n_lit_cnt;
    logic [AW-1:0]  r_idx,      n_idx;
    logic [DW-1:0]  r_pkt_cnt,  n_pkt_cnt;
    logic [DW-1:0]  r_pkt_byte, n_pkt_byte;
    logic [CW-1:0]  r_acc,      n_acc;
    logic [SW-1:0]  r_acc_n,    n_acc_n;
    logic           r_out_valid, n_out_valid;
    logic [CW-1:0]  r_out_word, n_out_word;
    logic [NW-1:0]  r_out_cnt,  n_out_cnt;
    logic           r_out_last, n_out_last;

    logic [LCW-1:0] lit_inc;
    logic           lit_at_end;
    logic [DW-1:0]  ram_rdata;
    logic [AW-1:0]  ram_raddr;
    logic           ram_we;
    logic [DW-1:0]  cur_byte;
    logic           push_need;
    logic           stall;
    logic           take_byte;
    logic           take_ram;
    logic [CW-1:0]  word;

    assign lit_inc    = r_lit_cnt + LCW'(1);
    assign lit_at_end = ((LCW'(r_idx) + LCW'(1)) == r_lit_cnt);

    // A result leaves the packer when its last lane fills or the request ends.
    assign push_need = i_cmd.byte_valid && ((r_acc_n == LAST_SLOT) || i_cmd.byte_last);
    assign stall     = push_need && r_out_valid && !i_out_ready;
    assign take_byte = i_cmd.byte_valid && !stall;
    assign take_ram  = take_byte && (i_cmd.byte_sel == rbe_pkg::SEL_RAM);

    assign ram_we = (i_cmd.op == rbe_pkg::OP_ADD_LIT) || (i_cmd.op == rbe_pkg::OP_FIN_LIT);

    // The read address runs one entry ahead whenever a stored byte is taken, so the
    // registered read data always matches the entry under the index.
    always_comb begin
        if (i_cmd.byte_valid && (i_cmd.byte_sel == rbe_pkg::SEL_RAM)) begin
            ram_raddr = take_ram ? (r_idx + AW'(1)) : r_idx;
        end else begin
            ram_raddr = '0;
        end
    end

    rbe_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_LITERAL_CHUNK)
    ) u_lit_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_lit_cnt[AW-1:0]),
        .i_wdata (r_prev),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        case (i_cmd.byte_sel)
            rbe_pkg::SEL_HDR:      cur_byte = DW'(r_lit_cnt) + HDR_BIAS;
            rbe_pkg::SEL_RAM:      cur_byte = ram_rdata;
            rbe_pkg::SEL_RUN_CNT:  cur_byte = r_pkt_cnt;
            rbe_pkg::SEL_RUN_BYTE: cur_byte = r_pkt_byte;
            default:               cur_byte = r_pkt_byte;
        endcase
    end

    always_comb begin
        word = r_acc;
        word[DW*r_acc_n +: DW] = cur_byte;
    end

    // Run and literal state.
    always_comb begin
        n_fin      = r_fin;
        n_prev     = r_prev;
        n_have     = r_have;
        n_run_cnt  = r_run_cnt;
        n_run_open = r_run_open;
        n_lit_cnt  = r_lit_cnt;
        n_idx      = r_idx;
        n_pkt_cnt  = r_pkt_cnt;
        n_pkt_byte = r_pkt_byte;
        if (i_cmd.take) begin
            n_fin = i_final_byte;
        end
        case (i_cmd.op)
            rbe_pkg::OP_START: begin
                n_prev     = i_data_byte;
                n_run_cnt  = DW'(1);
                n_run_open = 1'b0;
                n_have     = 1'b1;
            end
            rbe_pkg::OP_OPEN_RUN: begin
                n_run_open = 1'b1;
                n_run_cnt  = DW'(2);
            end
            rbe_pkg::OP_SPLIT_RUN: begin
                n_pkt_cnt  = r_run_cnt - DW'(1);
                n_pkt_byte = r_prev;
                n_run_cnt  = DW'(1);
            end
            rbe_pkg::OP_GROW: begin
                n_run_cnt = r_run_cnt + DW'(1);
            end
            rbe_pkg::OP_END_RUN: begin
                n_pkt_cnt  = r_run_cnt - DW'(1);
                n_pkt_byte = r_prev;
                n_run_open = 1'b0;
                n_prev     = i_data_byte;
                n_run_cnt  = DW'(1);
            end
            rbe_pkg::OP_ADD_LIT: begin
                n_lit_cnt = lit_inc;
                n_prev    = i_data_byte;
                n_run_cnt = DW'(1);
            end
            rbe_pkg::OP_FIN_RUN: begin
                n_pkt_cnt  = r_run_cnt - DW'(1);
                n_pkt_byte = r_prev;
            end
            rbe_pkg::OP_FIN_LIT: begin
                n_lit_cnt = lit_inc;
            end
            rbe_pkg::OP_CLEAR: begin
                n_prev     = '0;
                n_have     = 1'b0;
                n_run_cnt  = '0;
                n_run_open = 1'b0;
                n_lit_cnt  = '0;
                n_fin      = 1'b0;
            end
            default: begin
            end
        endcase
        if (take_ram) begin
            if (lit_at_end) begin
                n_lit_cnt = '0;
                n_idx     = '0;
            end else begin
                n_idx = r_idx + AW'(1);
            end
        end
    end

    // Packer and output register.
    always_comb begin
        n_acc       = r_acc;
        n_acc_n     = r_acc_n;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        n_out_cnt   = r_out_cnt;
        n_out_last  = r_out_last;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (take_byte) begin
            if (push_need) begin
                n_out_valid = 1'b1;
                n_out_word  = word;
                n_out_cnt   = NW'(r_acc_n) + NW'(1);
                n_out_last  = i_cmd.byte_last;
                n_acc       = '0;
                n_acc_n     = '0;
            end else begin
                n_acc   = word;
                n_acc_n = r_acc_n + SW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin       <= 1'b0;
            r_prev      <= '0;
            r_have      <= 1'b0;
            r_run_cnt   <= '0;
            r_run_open  <= 1'b0;
            r_lit_cnt   <= '0;
            r_idx       <= '0;
            r_acc       <= '0;
            r_acc_n     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fin       <= n_fin;
            r_prev      <= n_prev;
            r_have      <= n_have;
            r_run_cnt   <= n_run_cnt;
            r_run_open  <= n_run_open;
            r_lit_cnt   <= n_lit_cnt;
            r_idx       <= n_idx;
            r_acc       <= n_acc;
            r_acc_n     <= n_acc_n;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pkt_cnt  <= n_pkt_cnt;
        r_pkt_byte <= n_pkt_byte;
        r_out_word <= n_out_word;
        r_out_cnt  <= n_out_cnt;
        r_out_last <= n_out_last;
    end

    assign o_status.have_prev  = r_have;
    assign o_status.same_byte  = (i_data_byte == r_prev);
    assign o_status.run_open   = r_run_open;
    assign o_status.run_full   = (r_run_cnt >= RUN_MAX);
    assign o_status.fin_in     = i_final_byte;
    assign o_status.fin        = r_fin;
    assign o_status.lit_empty  = (r_lit_cnt == '0);
    assign o_status.lit_fill   = (lit_inc >= LIT_MAX);
    assign o_status.lit_at_end = lit_at_end;
    assign o_status.stall      = stall;

    assign o_out_valid    = r_out_valid;
    assign o_code_bytes   = r_out_word;
    assign o_code_count   = r_out_cnt;
    assign o_last_of_item = r_out_last;

`ifndef ASSERT_OFF
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_cnt <= RUN_MAX)
        else $error("run counter beyond the run chunk limit");

    // Opening a run flushes the pending literal, so literal bytes may only sit
    // beside an open run while that literal packet is being sent.
    a_run_no_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run_open && !i_cmd.byte_valid) |-> (r_lit_cnt == '0))
        else $error("literal bytes pending while a run is open");

    a_packer_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == rbe_pkg::OP_START || i_cmd.op == rbe_pkg::OP_CLEAR)
            |-> (r_acc_n == '0))
        else $error("packer holds bytes between requests");

    a_out_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_cnt != '0 && r_out_cnt <= NW'(BYTES_PER_RESULT)))
        else $error("result byte count out of range");
`endif
endmodule

`default_nettype wire

[rtl/rle_byte_encoder_core.sv]
// Top level of the run-length byte encoder: ties the controller to the datapath.
// Depends on rbe_pkg, rbe_in_if, rbe_out_if, rbe_ctrl, rbe_datapath and rbe_ram.
//
// Usage. Raw image bytes arrive on i_in, one per request, with final_byte set on
// the last byte of an image. Encoded output leaves on o_out as results of up to
// BYTES_PER_RESULT code bytes, first byte in bits 7:0, unused upper bytes zero;
// last_of_item marks the final result caused by one input request. A request that
// causes no code bytes produces no result at all.
// Sequencing: a request that only extends a run or buffers a literal returns the
// controller straight to idle. A request that emits code bytes holds off further
// requests while its code bytes are packed, then for the flush decision and the
// clearing of state when final_byte is set. The longest request fills the literal
// store and carries the final mark: 131 code bytes, the store read one entry per
// cycle unless stalled. Output: a result appears in the output register the cycle
// after its last code byte is packed. A waiting result does not block new input
// requests; only when the packer must hand over a further result while the output
// register is still full does the sequencer pause until the receiver takes it.
// Reset clears all run and literal state; the literal store needs no clearing,
// since only entries written within the current stretch are ever read.
`default_nettype none

module rle_byte_encoder_core #(
    parameter int MAX_RUN_CHUNK     = rbe_pkg::C_MAX_RUN_CHUNK,
    parameter int MAX_LITERAL_CHUNK = rbe_pkg::C_MAX_LITERAL_CHUNK,
    parameter int BYTES_PER_RESULT  = rbe_pkg::C_BYTES_PER_RESULT
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rbe_in_if.sink     i_in,
    rbe_out_if.source  o_out
);
    rbe_pkg::t_cmd    cmd;
    rbe_pkg::t_status status;
    logic             ready;

    assign i_in.ready = ready;

    // The controller sees only status flags and issues one command per cycle.
    rbe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (status),
        .o_ready    (ready),
        .o_cmd      (cmd)
    );

    // The datapath holds every byte of state, the literal store and the packer.
    rbe_datapath #(
        .MAX_RUN_CHUNK     (MAX_RUN_CHUNK),
        .MAX_LITERAL_CHUNK (MAX_LITERAL_CHUNK),
        .BYTES_PER_RESULT  (BYTES_PER_RESULT)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_data_byte    (i_in.data_byte),
        .i_final_byte   (i_in.final_byte),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_code_bytes   (o_out.code_bytes),
        .o_code_count   (o_out.code_count),
        .o_last_of_item (o_out.last_of_item)
    );
endmodule

`default_nettype wire
